// File: hdl/lse_pkg.sv
`default_nettype none

package lse_pkg;

  localparam int DATA_W          = 32;
  localparam int KIND_W          = 3;
  localparam int STATUS_W        = 3;
  localparam int MAX_RESULTS     = 64;
  localparam int LEN_W           = $clog2(MAX_RESULTS + 1);
  localparam int DEF_STACK_DEPTH = 64;
  // result queue depth, power of two so the pointers wrap on their own
  localparam int OQ_DEPTH        = 4;

  // input operation codes
  localparam logic [KIND_W-1:0] K_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] K_DUMP = 3'd1;
  localparam logic [KIND_W-1:0] K_PEEK = 3'd2;
  localparam logic [KIND_W-1:0] K_POP  = 3'd3;
  localparam logic [KIND_W-1:0] K_SWAP = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_SHOWN      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  // commands handed from front to back
  localparam logic [2:0] C_PUSH = 3'd0;
  localparam logic [2:0] C_ERR  = 3'd1;
  localparam logic [2:0] C_PEEK = 3'd2;
  localparam logic [2:0] C_SWAP = 3'd3;
  localparam logic [2:0] C_DUMP = 3'd4;

  typedef struct packed {
    logic [2:0]          op;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    len;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/lifo_stack_engine_core.sv
`default_nettype none

// LIFO stack engine: bounded stack of signed 32-bit values, one opcode per item.
// Input queue side: drive kind/push_value with push; a transfer happens when
// push is high and full is low. Result queue side: while empty is low the oldest
// result sits on status/shown_value/last_of_run; pop high transfers it.
// A front stage decodes ops against its own copy of the depth and queues
// commands (two entries) for a back stage that drives the stack RAM.
// Push is a RAM write in the back; good pop and unused codes never reach the
// back, so such items go in at one per cycle while full is low. Peek and error
// results wait for a result queue slot; swap does two reads and two writes on
// the single stack RAM port pair. Dump shows the stack from the top down,
// capped at 64 entries. With the back idle, a result passes the RAM read stage
// and then the result queue before it is on the result ports.
// When the receiver stalls, the four-entry result queue fills, the back stops,
// the command queue fills and full rises; nothing is dropped.
// Synchronous reset empties the stack and both queues; stack RAM contents are
// not cleared and need no clearing pass.

module lifo_stack_engine_core import lse_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic        [KIND_W-1:0]   kind,
  input  wire logic signed [DATA_W-1:0]   push_value,
  output logic                            empty,
  input  wire logic                       pop,
  output logic             [STATUS_W-1:0] status,
  output logic signed      [DATA_W-1:0]   shown_value,
  output logic                            last_of_run
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic              cmd_valid;
  cmd_t              cmd;
  logic [AW-1:0]     cmd_addr;
  logic [DATA_W-1:0] cmd_value;
  logic              cmd_take;
  logic [DATA_W-1:0] shown_raw;

  lse_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_addr   (cmd_addr),
    .cmd_value  (cmd_value),
    .cmd_take   (cmd_take)
  );

  lse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_addr    (cmd_addr),
    .cmd_value   (cmd_value),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .shown_value (shown_raw),
    .last_of_run (last_of_run)
  );

  assign shown_value = shown_raw;

endmodule

`default_nettype wire

// File: hdl/lse_ram.sv
`default_nettype none

module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/lse_front.sv
`default_nettype none

module lse_front import lse_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [KIND_W-1:0]                kind,
  input  wire logic [DATA_W-1:0]                push_value,
  output logic                                  cmd_valid,
  output cmd_t                                  cmd,
  output logic      [$clog2(STACK_DEPTH)-1:0]   cmd_addr,
  output logic      [DATA_W-1:0]                cmd_value,
  input  wire logic                             cmd_take
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int MW = (CW > LEN_W) ? CW : LEN_W;

  // the front tracks the depth itself: the count only depends on the op sequence
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic [MW-1:0]     cnt_ext;
  logic [AW-1:0]     top_addr;
  logic              accept;
  logic              keep;
  cmd_t              c_cmd;
  logic [AW-1:0]     c_addr;

  cmd_t              q_cmd   [2];
  logic [AW-1:0]     q_addr  [2];
  logic [DATA_W-1:0] q_value [2];
  logic              wp;
  logic              rp;
  logic [1:0]        qcount;

  assign full     = (qcount == 2'd2);
  assign accept   = push && !full;
  assign cnt_ext  = MW'(cnt);
  assign top_addr = AW'(cnt - 1'b1);

  always_comb begin
    keep         = 1'b0;
    c_cmd.op     = C_ERR;
    c_cmd.status = ST_SHOWN;
    c_cmd.len    = '0;
    c_addr       = top_addr;
    cnt_next     = cnt;
    case (kind)
      K_PUSH: begin
        keep = 1'b1;
        if (cnt == CW'(STACK_DEPTH)) begin
          c_cmd.status = ST_FULL;
        end else begin
          c_cmd.op = C_PUSH;
          c_addr   = AW'(cnt);
          cnt_next = cnt + 1'b1;
        end
      end
      K_DUMP: begin
        if (cnt != '0) begin
          keep     = 1'b1;
          c_cmd.op = C_DUMP;
          c_cmd.len = (cnt_ext > MW'(MAX_RESULTS)) ? LEN_W'(MAX_RESULTS) : LEN_W'(cnt_ext);
        end
      end
      K_PEEK: begin
        keep = 1'b1;
        if (cnt == '0) begin
          c_cmd.status = ST_PEEK_EMPTY;
        end else begin
          c_cmd.op = C_PEEK;
        end
      end
      K_POP: begin
        // a good pop only moves the count; the back never sees it
        if (cnt == '0) begin
          keep         = 1'b1;
          c_cmd.status = ST_POP_EMPTY;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      K_SWAP: begin
        keep = 1'b1;
        if (cnt < CW'(2)) begin
          c_cmd.status = ST_SWAP_SHORT;
        end else begin
          c_cmd.op = C_SWAP;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wp     <= 1'b0;
      rp     <= 1'b0;
      qcount <= '0;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
      end
      if (accept && keep) begin
        wp <= ~wp;
      end
      if (cmd_take) begin
        rp <= ~rp;
      end
      qcount <= qcount + {1'b0, accept && keep} - {1'b0, cmd_take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q_cmd[wp]   <= c_cmd;
      q_addr[wp]  <= c_addr;
      q_value[wp] <= push_value;
    end
  end

  assign cmd_valid = (qcount != '0);
  assign cmd       = q_cmd[rp];
  assign cmd_addr  = q_addr[rp];
  assign cmd_value = q_value[rp];

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> qcount != '0)
    else $error("command taken from an empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == K_PUSH && cnt != CW'(STACK_DEPTH)) |=> cnt == $past(cnt) + 1'b1)
    else $error("push did not advance the depth");

endmodule

`default_nettype wire

// File: hdl/lse_back.sv
`default_nettype none

module lse_back import lse_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  input  wire cmd_t                           cmd,
  input  wire logic [$clog2(STACK_DEPTH)-1:0] cmd_addr,
  input  wire logic [DATA_W-1:0]              cmd_value,
  output logic                                cmd_take,
  output logic                                empty,
  input  wire logic                           pop,
  output logic      [STATUS_W-1:0]            status,
  output logic      [DATA_W-1:0]              shown_value,
  output logic                                last_of_run
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int OAW = $clog2(OQ_DEPTH);
  localparam int OCW = $clog2(OQ_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DUMP = 3'd1;
  localparam logic [2:0] S_SW1  = 3'd2;
  localparam logic [2:0] S_SW2  = 3'd3;
  localparam logic [2:0] S_SW3  = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [AW-1:0]       d_addr;
  logic [LEN_W-1:0]    d_len;
  logic [AW-1:0]       sw_addr;
  logic [DATA_W-1:0]   tmp;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DATA_W-1:0]   wdata;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rdata;

  logic                issue;
  logic [STATUS_W-1:0] issue_status;
  logic                issue_ram;
  logic                issue_last;
  logic                room;

  // one stage lines results up with the registered RAM read
  logic                pend_v;
  logic [STATUS_W-1:0] pend_status;
  logic                pend_ram;
  logic                pend_last;

  logic [STATUS_W-1:0] o_status [OQ_DEPTH];
  logic [DATA_W-1:0]   o_value  [OQ_DEPTH];
  logic                o_last   [OQ_DEPTH];
  logic [OAW-1:0]      owp;
  logic [OAW-1:0]      orp;
  logic [OCW-1:0]      ocount;
  logic                deq;

  lse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // reserve a queue slot for the result staged in pend
  assign room = (ocount + OCW'(pend_v)) < OCW'(OQ_DEPTH);

  always_comb begin
    state_next   = state;
    cmd_take     = 1'b0;
    we           = 1'b0;
    waddr        = cmd_addr;
    wdata        = cmd_value;
    raddr        = cmd_addr;
    issue        = 1'b0;
    issue_status = ST_SHOWN;
    issue_ram    = 1'b0;
    issue_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            C_PUSH: begin
              we       = 1'b1;
              cmd_take = 1'b1;
            end
            C_ERR: begin
              if (room) begin
                issue        = 1'b1;
                issue_status = cmd.status;
                cmd_take     = 1'b1;
              end
            end
            C_PEEK: begin
              if (room) begin
                issue     = 1'b1;
                issue_ram = 1'b1;
                cmd_take  = 1'b1;
              end
            end
            C_SWAP: begin
              cmd_take   = 1'b1;
              state_next = S_SW1;
            end
            C_DUMP: begin
              cmd_take   = 1'b1;
              state_next = S_DUMP;
            end
            default: begin
              cmd_take = 1'b1;
            end
          endcase
        end
      end
      S_DUMP: begin
        raddr = d_addr;
        if (room) begin
          issue      = 1'b1;
          issue_ram  = 1'b1;
          issue_last = (d_len == LEN_W'(1));
          if (d_len == LEN_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SW1: begin
        raddr      = sw_addr - 1'b1;
        state_next = S_SW2;
      end
      S_SW2: begin
        we         = 1'b1;
        waddr      = sw_addr;
        wdata      = rdata;
        state_next = S_SW3;
      end
      S_SW3: begin
        we         = 1'b1;
        waddr      = sw_addr - 1'b1;
        wdata      = tmp;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign deq = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend_v <= 1'b0;
      owp    <= '0;
      orp    <= '0;
      ocount <= '0;
    end else begin
      state  <= state_next;
      pend_v <= issue;
      if (pend_v) begin
        owp <= owp + 1'b1;
      end
      if (deq) begin
        orp <= orp + 1'b1;
      end
      ocount <= ocount + OCW'(pend_v) - OCW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= issue_status;
    pend_ram    <= issue_ram;
    pend_last   <= issue_last;
    if (state == S_IDLE) begin
      d_addr  <= cmd_addr;
      d_len   <= cmd.len;
      sw_addr <= cmd_addr;
    end else if (state == S_DUMP && room) begin
      d_addr <= d_addr - 1'b1;
      d_len  <= d_len - 1'b1;
    end
    if (state == S_SW1) begin
      tmp <= rdata;
    end
    if (pend_v) begin
      o_status[owp] <= pend_status;
      o_value[owp]  <= pend_ram ? rdata : '0;
      o_last[owp]   <= pend_last;
    end
  end

  assign empty       = (ocount == '0);
  assign status      = o_status[orp];
  assign shown_value = o_value[orp];
  assign last_of_run = o_last[orp];

  a_pend_has_room: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> ocount < OCW'(OQ_DEPTH))
    else $error("staged result has no queue slot");

  a_dump_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> d_len != '0)
    else $error("dump running with zero entries left");

  a_swap_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_SW2 |=> state == S_SW3)
    else $error("swap write sequence broken");

endmodule

`default_nettype wire
